>>> design/agr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine trilinear grid resampler package
// Shared widths, configuration register indexes and stage payload types.
// ----------------------------------------------------------------------------
package agr_pkg;

  localparam int DIM_MAX    = 64;
  localparam int AXIS_W     = 6;
  localparam int HALF_W     = AXIS_W - 1;
  localparam int BANK_ADDRW = 3 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_ADDRW;
  localparam int NUM_BANKS  = 8;
  localparam int SMP_W      = 16;
  localparam int FRAC_W     = 12;
  localparam int COORD_W    = 21;
  localparam int BASIS_W    = 16;
  localparam int CELL_W     = COORD_W - FRAC_W;
  localparam int PROD_W     = BASIS_W + AXIS_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DIM_W      = 7;
  localparam int ROW_W      = 3 * BASIS_W;
  localparam int ORIGIN_W   = 3 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ORIGIN_W;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_I,
    CFG_DIM_J,
    CFG_DIM_K,
    CFG_BASIS_0,
    CFG_BASIS_1,
    CFG_BASIS_2,
    CFG_ORIGIN
  } cfg_reg_t;

  typedef struct packed {
    logic                    kind;
    logic [AXIS_W-1:0]       i;
    logic [AXIS_W-1:0]       j;
    logic [AXIS_W-1:0]       k;
    logic signed [SMP_W-1:0] smp;
  } item_t;

  typedef struct packed {
    logic                      kind;
    logic [AXIS_W-1:0]         i;
    logic [AXIS_W-1:0]         j;
    logic [AXIS_W-1:0]         k;
    logic signed [SMP_W-1:0]   smp;
    logic [2:0][CELL_W-1:0]    base;
    logic [2:0][FRAC_W-1:0]    frac;
  } mapped_t;

  typedef struct packed {
    logic                   outside;
    logic [2:0]             par;
    logic [NUM_BANKS-1:0]   live;
    logic [2:0][FRAC_W-1:0] frac;
  } fetch_t;

endpackage

>>> design/affine_trilinear_grid_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine trilinear grid resampler
// Loads samples into a 3D grid store and answers each query with the
// trilinear blend at the affine-mapped coordinate of an output voxel.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  kind, idx_i, idx_j, idx_k, sample
//   out      output     out_valid/out_stall  interp_value
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// One item per cycle is taken while in_stall is low; a query result passes
// through the seven register stages from input to output register, the
// first of which captures the transfer.
// Loads give no result and write the store from the mapped register m3.
// Reset clears control state and restores the registers; the store is not
// cleared. A stall of a valid output halts every stage and raises in_stall.
// ----------------------------------------------------------------------------
module affine_trilinear_grid_resampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [agr_pkg::AXIS_W-1:0]          idx_i,
  input  logic [agr_pkg::AXIS_W-1:0]          idx_j,
  input  logic [agr_pkg::AXIS_W-1:0]          idx_k,
  input  logic signed [agr_pkg::SMP_W-1:0]    sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [agr_pkg::SMP_W-1:0]    interp_value,
  input  logic                                cfg_write,
  input  logic [agr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [agr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import agr_pkg::*;

  logic [DIM_W-1:0]    dim_i, dim_j, dim_k;
  logic [ROW_W-1:0]    basis_row_0, basis_row_1, basis_row_2;
  logic [ORIGIN_W-1:0] grid_origin;
  logic [2:0][DIM_W-1:0] dims;
  logic                en;
  item_t               item;
  logic                v3, v4;
  mapped_t             m3;
  fetch_t              f4;
  logic [NUM_BANKS-1:0][SMP_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_i       <= DIM_W'(64);
      dim_j       <= DIM_W'(64);
      dim_k       <= DIM_W'(64);
      basis_row_0 <= ROW_W'(48'h0000_0000_1000);
      basis_row_1 <= ROW_W'(48'h0000_1000_0000);
      basis_row_2 <= ROW_W'(48'h1000_0000_0000);
      grid_origin <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DIM_I:   dim_i       <= cfg_data[DIM_W-1:0];
        CFG_DIM_J:   dim_j       <= cfg_data[DIM_W-1:0];
        CFG_DIM_K:   dim_k       <= cfg_data[DIM_W-1:0];
        CFG_BASIS_0: basis_row_0 <= cfg_data[ROW_W-1:0];
        CFG_BASIS_1: basis_row_1 <= cfg_data[ROW_W-1:0];
        CFG_BASIS_2: basis_row_2 <= cfg_data[ROW_W-1:0];
        CFG_ORIGIN:  grid_origin <= cfg_data[ORIGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dims[0] = (dim_i > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : dim_i;
    dims[1] = (dim_j > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : dim_j;
    dims[2] = (dim_k > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : dim_k;
    en       = !(out_valid && out_stall);
    in_stall = !en;
    item     = '{kind: kind, i: idx_i, j: idx_j, k: idx_k, smp: sample};
  end

  agr_xform u_xform (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .take   (in_valid),
    .item   (item),
    .row0   (basis_row_0),
    .row1   (basis_row_1),
    .row2   (basis_row_2),
    .origin (grid_origin),
    .v3     (v3),
    .m3     (m3)
  );

  agr_grid u_grid (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .v3    (v3),
    .m3    (m3),
    .dims  (dims),
    .v4    (v4),
    .f4    (f4),
    .rdata (rdata)
  );

  agr_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v4        (v4),
    .f4        (f4),
    .rdata     (rdata),
    .out_valid (out_valid),
    .value     (interp_value)
  );

endmodule

>>> design/agr_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate transform
// Registers the input, forms the nine index-times-basis products, then adds
// the origin, saturates each coordinate and splits it into cell and fraction.
// ----------------------------------------------------------------------------
module agr_xform (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              take,
  input  agr_pkg::item_t                    item,
  input  logic [agr_pkg::ROW_W-1:0]         row0,
  input  logic [agr_pkg::ROW_W-1:0]         row1,
  input  logic [agr_pkg::ROW_W-1:0]         row2,
  input  logic [agr_pkg::ORIGIN_W-1:0]      origin,
  output logic                              v3,
  output agr_pkg::mapped_t                  m3
);
  import agr_pkg::*;

  localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] CMIN = -SUM_W'(1 << (COORD_W - 1));

  logic                     v1, v2;
  item_t                    s1, s2;
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [SUM_W-1:0]  sum  [3];
  logic signed [SUM_W-1:0]  csat [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= item;
      s2 <= s1;
      for (int a = 0; a < 3; a++) begin
        prod[0][a] <= $signed({1'b0, s1.i}) * $signed(row0[BASIS_W*a +: BASIS_W]);
        prod[1][a] <= $signed({1'b0, s1.j}) * $signed(row1[BASIS_W*a +: BASIS_W]);
        prod[2][a] <= $signed({1'b0, s1.k}) * $signed(row2[BASIS_W*a +: BASIS_W]);
      end
      m3.kind <= s2.kind;
      m3.i    <= s2.i;
      m3.j    <= s2.j;
      m3.k    <= s2.k;
      m3.smp  <= s2.smp;
      for (int a = 0; a < 3; a++) begin
        m3.base[a] <= csat[a][COORD_W-1:FRAC_W];
        m3.frac[a] <= csat[a][FRAC_W-1:0];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = SUM_W'($signed(origin[COORD_W*a +: COORD_W]))
             + SUM_W'(prod[0][a]) + SUM_W'(prod[1][a]) + SUM_W'(prod[2][a]);
      if (sum[a] > CMAX) begin
        csat[a] = CMAX;
      end else if (sum[a] < CMIN) begin
        csat[a] = CMIN;
      end else begin
        csat[a] = sum[a];
      end
    end
  end

endmodule

>>> design/agr_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid store
// Eight banks split by coordinate parity, so that all corners of one cell
// are read in the same cycle. Loads write one bank in the same stage.
// ----------------------------------------------------------------------------
module agr_grid (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  v3,
  input  agr_pkg::mapped_t                      m3,
  input  logic [2:0][agr_pkg::DIM_W-1:0]        dims,
  output logic                                  v4,
  output agr_pkg::fetch_t                       f4,
  output logic [agr_pkg::NUM_BANKS-1:0][agr_pkg::SMP_W-1:0] rdata
);
  import agr_pkg::*;

  localparam int CW = CELL_W + 1;

  logic [BANK_ADDRW-1:0]   raddr [NUM_BANKS];
  logic [NUM_BANKS-1:0]    live;
  logic [2:0]              wbank;
  logic [BANK_ADDRW-1:0]   waddr;
  logic                    wr;
  logic                    outside;
  logic signed [CW-1:0]    pos  [3];
  logic signed [CW-1:0]    bc   [3];
  logic signed [CW-1:0]    lc   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = CW'($signed(m3.base[a]));
    end
    outside = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (pos[a] < -CW'(1) || pos[a] >= $signed(CW'(dims[a]))) begin
        outside = 1'b1;
      end
    end
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int a = 0; a < 3; a++) begin
        bc[a] = pos[a] + CW'(b[2-a] ^ m3.base[a][0]);
      end
      raddr[b] = {bc[0][HALF_W:1], bc[1][HALF_W:1], bc[2][HALF_W:1]};
      for (int a = 0; a < 3; a++) begin
        lc[a] = pos[a] + CW'(b[2-a]);
      end
      live[b] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        if (lc[a] < 0 || lc[a] >= $signed(CW'(dims[a]))) begin
          live[b] = 1'b0;
        end
      end
    end
    wbank = {m3.i[0], m3.j[0], m3.k[0]};
    waddr = {m3.i[AXIS_W-1:1], m3.j[AXIS_W-1:1], m3.k[AXIS_W-1:1]};
    wr    = en && v3 && (m3.kind == KIND_LOAD);
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [SMP_W-1:0] mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr && wbank == 3'(g)) begin
        mem[waddr] <= m3.smp;
      end
      if (en) begin
        rdata[g] <= mem[raddr[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3 && (m3.kind == KIND_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4.outside <= outside;
      f4.par     <= {m3.base[0][0], m3.base[1][0], m3.base[2][0]};
      f4.live    <= live;
      f4.frac    <= m3.frac;
    end
  end

endmodule

>>> design/agr_interp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trilinear blend
// Three blend stages: along the first, second and third axis, each a
// truncating fixed-point weighted sum of two values.
// ----------------------------------------------------------------------------
module agr_interp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  v4,
  input  agr_pkg::fetch_t                       f4,
  input  logic [agr_pkg::NUM_BANKS-1:0][agr_pkg::SMP_W-1:0] rdata,
  output logic                                  out_valid,
  output logic signed [agr_pkg::SMP_W-1:0]      value
);
  import agr_pkg::*;

  localparam int W_W = FRAC_W + 2;
  localparam int P_W = SMP_W + W_W + 1;

  function automatic logic signed [SMP_W-1:0] blend(
    input logic signed [SMP_W-1:0] a,
    input logic signed [SMP_W-1:0] b,
    input logic [FRAC_W-1:0]       f
  );
    logic signed [W_W-1:0] wa;
    logic signed [W_W-1:0] wb;
    logic signed [P_W-1:0] s;
    wb = $signed({2'b00, f});
    wa = W_W'(1 << FRAC_W) - wb;
    s  = P_W'(a) * P_W'(wa) + P_W'(b) * P_W'(wb);
    return s[FRAC_W +: SMP_W];
  endfunction

  logic signed [SMP_W-1:0] corner [NUM_BANKS];
  logic                    v5, v6;
  logic                    out5, out6;
  logic [FRAC_W-1:0]       fj5, fk5, fk6;
  logic signed [SMP_W-1:0] c00, c01, c10, c11, c0, c1;

  always_comb begin
    for (int d = 0; d < NUM_BANKS; d++) begin
      corner[d] = f4.live[d] ? $signed(rdata[3'(d) ^ f4.par]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out5  <= f4.outside;
      fj5   <= f4.frac[1];
      fk5   <= f4.frac[2];
      c00   <= blend(corner[0], corner[4], f4.frac[0]);
      c01   <= blend(corner[1], corner[5], f4.frac[0]);
      c10   <= blend(corner[2], corner[6], f4.frac[0]);
      c11   <= blend(corner[3], corner[7], f4.frac[0]);
      out6  <= out5;
      fk6   <= fk5;
      c0    <= blend(c00, c10, fj5);
      c1    <= blend(c01, c11, fj5);
      value <= out6 ? '0 : blend(c0, c1, fk6);
    end
  end

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    en && v6 && out6 |=> value == '0)
    else $error("cell outside the grid gave a nonzero value");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v5) && $stable(v6) && $stable(out_valid))
    else $error("blend stages moved while stalled");

  a_valid_flow: assert property (@(posedge clk) disable iff (rst)
    en && v5 |=> v6)
    else $error("query lost between blend stages");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the affine trilinear grid resampler
// A table of directed loads and queries runs first against the reset
// settings. Then a series of phases follows, each with new grid sizes, basis
// rows and origin. Each phase fills a small block of the store, if its grid
// sizes allow one, and then mixes random queries with random loads. An
// in-bench model of the affine map and the trilinear blend predicts each
// query result that the table does not give, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import agr_pkg::*;

  localparam int DRAIN = 16;
  localparam int STORE_N = DIM_MAX * DIM_MAX * DIM_MAX;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_LOAD;
  logic [AXIS_W-1:0] idx_i = '0, idx_j = '0, idx_k = '0;
  logic signed [SMP_W-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SMP_W-1:0] interp_value;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DIM_I;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  affine_trilinear_grid_resampler u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .idx_i(idx_i), .idx_j(idx_j), .idx_k(idx_k), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .interp_value(interp_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: registers and grid contents.
  logic [DIM_W-1:0] dim_i_r, dim_j_r, dim_k_r;
  logic [ROW_W-1:0] row_r [3];
  logic [ORIGIN_W-1:0] origin_r;
  logic signed [SMP_W-1:0] grid_mem [STORE_N];
  bit loaded [STORE_N];
  bit hole_hit;

  logic signed [SMP_W-1:0] voxel_q [$];
  int errors = 0;
  int mismatches = 0;
  int results_seen = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  bit steady = 1'b0;

  typedef struct {
    bit kind;
    int i;
    int j;
    int k;
    int smp;
    bit known;
    int val;
  } dir_row_t;
  dir_row_t dir_rows [$];

  function automatic void add_row(bit kd, int i, int j, int k, int smp, bit known, int val);
    dir_row_t r;
    r = '{kd, i, j, k, smp, known, val};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic longint eff_dim(logic [DIM_W-1:0] d);
    return (d > DIM_MAX) ? DIM_MAX : longint'(d);
  endfunction

  function automatic longint grid_at(longint i, longint j, longint k, longint di,
                                     longint dj, longint dk);
    int addr;
    if (i < 0 || j < 0 || k < 0 || i >= di || j >= dj || k >= dk) return 0;
    addr = int'((i * DIM_MAX + j) * DIM_MAX + k);
    if (!loaded[addr]) hole_hit = 1'b1;
    return longint'(grid_mem[addr]);
  endfunction

  function automatic longint mix(longint a, longint b, longint f);
    return (a * (64'sd4096 - f) + b * f) >>> FRAC_W;
  endfunction

  function automatic logic signed [SMP_W-1:0] resample(int ii, int jj, int kk);
    longint base [3];
    longint frac [3];
    longint dm [3];
    longint c, u, c00, c01, c10, c11, c0, c1, v;
    dm[0] = eff_dim(dim_i_r);
    dm[1] = eff_dim(dim_j_r);
    dm[2] = eff_dim(dim_k_r);
    for (int a = 0; a < 3; a++) begin
      c = longint'($signed(origin_r[a*COORD_W +: COORD_W]))
        + ii * longint'($signed(row_r[0][a*BASIS_W +: BASIS_W]))
        + jj * longint'($signed(row_r[1][a*BASIS_W +: BASIS_W]))
        + kk * longint'($signed(row_r[2][a*BASIS_W +: BASIS_W]));
      if (c > 64'sd1048575) c = 64'sd1048575;
      if (c < -64'sd1048576) c = -64'sd1048576;
      u = c + 64'sd1048576;
      base[a] = (u >>> FRAC_W) - 256;
      frac[a] = u & 64'sd4095;
    end
    for (int a = 0; a < 3; a++)
      if (base[a] < -1 || base[a] >= dm[a]) return '0;
    c00 = mix(grid_at(base[0], base[1], base[2], dm[0], dm[1], dm[2]),
              grid_at(base[0]+1, base[1], base[2], dm[0], dm[1], dm[2]), frac[0]);
    c01 = mix(grid_at(base[0], base[1], base[2]+1, dm[0], dm[1], dm[2]),
              grid_at(base[0]+1, base[1], base[2]+1, dm[0], dm[1], dm[2]), frac[0]);
    c10 = mix(grid_at(base[0], base[1]+1, base[2], dm[0], dm[1], dm[2]),
              grid_at(base[0]+1, base[1]+1, base[2], dm[0], dm[1], dm[2]), frac[0]);
    c11 = mix(grid_at(base[0], base[1]+1, base[2]+1, dm[0], dm[1], dm[2]),
              grid_at(base[0]+1, base[1]+1, base[2]+1, dm[0], dm[1], dm[2]), frac[0]);
    c0 = mix(c00, c10, frac[1]);
    c1 = mix(c01, c11, frac[1]);
    v = mix(c0, c1, frac[2]);
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < -64'sd32768) v = -64'sd32768;
    return SMP_W'(v);
  endfunction

  function automatic bit query_is_safe(int ii, int jj, int kk);
    logic signed [SMP_W-1:0] unused;
    hole_hit = 1'b0;
    unused = resample(ii, jj, kk);
    return !hole_hit;
  endfunction

  // Drives one item and records its expected effect at the transfer edge.
  task automatic send_item(bit kd, int ii, int jj, int kk, int smp, bit known = 1'b0,
                           int val = 0);
    int addr;
    while (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= kd;
    idx_i <= AXIS_W'(ii);
    idx_j <= AXIS_W'(jj);
    idx_k <= AXIS_W'(kk);
    sample <= SMP_W'(smp);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kd == KIND_LOAD) begin
      addr = (ii * DIM_MAX + jj) * DIM_MAX + kk;
      grid_mem[addr] = SMP_W'(smp);
      loaded[addr] = 1'b1;
      loads_sent++;
    end else begin
      voxel_q.insert(voxel_q.size(), known ? SMP_W'(val) : resample(ii, jj, kk));
      queries_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (voxel_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_DIM_I: dim_i_r = val[DIM_W-1:0];
      CFG_DIM_J: dim_j_r = val[DIM_W-1:0];
      CFG_DIM_K: dim_k_r = val[DIM_W-1:0];
      CFG_BASIS_0: row_r[0] = val[ROW_W-1:0];
      CFG_BASIS_1: row_r[1] = val[ROW_W-1:0];
      CFG_BASIS_2: row_r[2] = val[ROW_W-1:0];
      CFG_ORIGIN: origin_r = val[ORIGIN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [BASIS_W-1:0] pick_step(int mode);
    if (mode == 1) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if (mode == 2) return BASIS_W'($urandom);
    return BASIS_W'($urandom_range(12288) - 6144);
  endfunction

  function automatic logic [COORD_W-1:0] pick_origin(int mode);
    if (mode == 1) return $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
    if (mode == 2) return COORD_W'($urandom);
    return COORD_W'($urandom_range(24576) - 8192);
  endfunction

  // Random phase: new settings, fill a small block, then mixed traffic.
  task automatic run_phase(int ph, int n_items);
    logic [DIM_W-1:0] d [3];
    logic [ROW_W-1:0] rows [3];
    logic [ORIGIN_W-1:0] org;
    int mode, lim, ii, jj, kk, tries;
    bit ok;
    wait_idle();
    mode = (ph % 5 == 3) ? 1 : ((ph % 5 == 4) ? 2 : 0);
    for (int a = 0; a < 3; a++) begin
      case (ph)
        1: d[a] = '0;
        2: d[a] = 7'd127;
        3: d[a] = 7'd64;
        4: d[a] = 7'd1;
        default: d[a] = DIM_W'($urandom_range(5, 2));
      endcase
      rows[a] = {pick_step(mode), pick_step(mode), pick_step(mode)};
    end
    org = {pick_origin(mode), pick_origin(mode), pick_origin(mode)};
    if (ph == 6) rows[0] = {16'd0, 16'd0, 16'd2048};
    write_reg(CFG_DIM_I, CFG_DATA_W'(d[0]));
    write_reg(CFG_DIM_J, CFG_DATA_W'(d[1]));
    write_reg(CFG_DIM_K, CFG_DATA_W'(d[2]));
    write_reg(CFG_BASIS_0, CFG_DATA_W'(rows[0]));
    write_reg(CFG_BASIS_1, CFG_DATA_W'(rows[1]));
    write_reg(CFG_BASIS_2, CFG_DATA_W'(rows[2]));
    write_reg(CFG_ORIGIN, org);
    if (ph == 1) write_reg(CFG_SPARE, '1);
    cfg_write <= 1'b0;
    @(posedge clk);
    steady = (ph == 7);
    lim = (d[0] > 6) ? 6 : d[0];
    for (int i = 0; i < lim; i++)
      for (int j = 0; j < ((d[1] > 6) ? 6 : d[1]); j++)
        for (int k = 0; k < ((d[2] > 6) ? 6 : d[2]); k++)
          send_item(KIND_LOAD, i, j, k, $urandom_range(65535));
    for (int n = 0; n < n_items; n++) begin
      if (ph == 5 && n == n_items / 2) wait_idle();
      if ($urandom_range(99) < 20) begin
        send_item(KIND_LOAD, $urandom_range(63), $urandom_range(63), $urandom_range(63),
                  $urandom_range(65535));
      end else begin
        ok = 1'b0;
        tries = 0;
        while (!ok && tries < 30) begin
          if ($urandom_range(3) == 0) begin
            ii = $urandom_range(63);
            jj = $urandom_range(63);
            kk = $urandom_range(63);
          end else begin
            ii = $urandom_range(7);
            jj = $urandom_range(7);
            kk = $urandom_range(7);
          end
          ok = query_is_safe(ii, jj, kk);
          tries++;
        end
        if (ok) send_item(KIND_QUERY, ii, jj, kk, $urandom_range(65535));
        else send_item(KIND_LOAD, ii, jj, kk, $urandom_range(65535));
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !steady && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    logic signed [SMP_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (voxel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected transfer: interp_value %0d", interp_value);
      end else begin
        want = voxel_q.pop_front();
        if (interp_value !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: interp_value expected %0d, got %0d", want, interp_value);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", voxel_q.size());
    $display("tb_top failed");
    $finish;
  end

  initial begin
    dim_i_r = 7'd64;
    dim_j_r = 7'd64;
    dim_k_r = 7'd64;
    row_r[0] = 48'd4096;
    row_r[1] = 48'd268435456;
    row_r[2] = 48'd17592186044416;
    origin_r = '0;
    add_row(KIND_LOAD, 0, 0, 0, 32767, 1'b0, 0);
    add_row(KIND_LOAD, 1, 0, 0, -32768, 1'b0, 0);
    add_row(KIND_LOAD, 0, 1, 0, 0, 1'b0, 0);
    add_row(KIND_LOAD, 1, 1, 0, 1, 1'b0, 0);
    add_row(KIND_LOAD, 0, 0, 1, -1, 1'b0, 0);
    add_row(KIND_LOAD, 1, 0, 1, 100, 1'b0, 0);
    add_row(KIND_LOAD, 0, 1, 1, -100, 1'b0, 0);
    add_row(KIND_LOAD, 1, 1, 1, 12345, 1'b0, 0);
    add_row(KIND_LOAD, 63, 63, 63, -32768, 1'b0, 0);
    add_row(KIND_QUERY, 0, 0, 0, -1, 1'b1, 32767);
    add_row(KIND_QUERY, 63, 63, 63, 21845, 1'b1, -32768);
    add_row(KIND_LOAD, 63, 63, 63, 21845, 1'b0, 0);
    add_row(KIND_QUERY, 63, 63, 63, 0, 1'b1, 21845);
    add_row(KIND_LOAD, 0, 0, 0, -21846, 1'b0, 0);
    add_row(KIND_QUERY, 0, 0, 0, 32767, 1'b1, -21846);
    add_row(KIND_QUERY, 0, 0, 0, 0, 1'b0, 0);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[r])
      send_item(dir_rows[r].kind, dir_rows[r].i, dir_rows[r].j, dir_rows[r].k,
                dir_rows[r].smp, dir_rows[r].known, dir_rows[r].val);
    for (int ph = 1; ph <= 12; ph++) run_phase(ph, 85);
    wait_idle();
    $display("Covered %0d loads and %0d queries over 12 register settings,", loads_sent,
             queries_sent);
    $display("with %0d results checked and %0d errors.", results_seen, errors);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
